### src/hsi_to_rgb_pixel_assert.svh
// Assertion macros shared by the HSI to RGB pixel converter modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HSI_TO_RGB_PIXEL_ASSERT_SVH
`define HSI_TO_RGB_PIXEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSI2RGB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen outside reset.
`define HSI2RGB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

### src/hsi2rgb_pkg.sv
// Shared types, constants and the hue ratio table of the HSI to RGB converter.
// No dependencies; every design module imports this package.
package hsi2rgb_pkg;

  localparam int RATIO_FRAC_BITS = 14;
  localparam int RATIO_W         = RATIO_FRAC_BITS + 3;
  localparam int HUE_STEPS       = 256;
  localparam int SECTOR_RG_MAX   = 85;
  localparam int SECTOR_GB_MAX   = 170;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  // Accept edge to the edge that samples the result strobe.
  localparam int PIPE_LATENCY    = 7;

  // Constants of the table generator: cosine in Q28 by a Taylor series.
  localparam logic [63:0] PI_Q28    = 64'd843314857;
  localparam logic [63:0] ONE_Q28   = 64'd268435456;
  localparam int          COS_TERMS = 14;

  typedef logic signed [RATIO_W-1:0] ratio_t;
  typedef ratio_t ratio_rom_t [HUE_STEPS];

  typedef enum logic [1:0] {
    SECTOR_RG,
    SECTOR_GB,
    SECTOR_BR
  } sector_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] intensity;
  } hsi_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // One classified pixel waiting for the arithmetic back end.
  typedef struct packed {
    sector_t    sector;
    logic [7:0] saturation;
    logic [7:0] intensity;
    ratio_t     ratio;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t entry;
  } qxfer_t;

  // Shift-subtract division, used only while the table is built at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos(m * pi / 384) in Q28.
  function automatic logic signed [63:0] cos_q28(input logic [31:0] m);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    x   = udiv64(64'(m) * PI_Q28 + 64'd192, 64'd384);
    x2  = (x * x + (64'd1 << 27)) >> 28;
    t   = ONE_Q28;
    sum = $signed(ONE_Q28);
    for (int n = 1; n <= COS_TERMS; n++) begin
      t = udiv64((t * x2) >> 28, 64'((2 * n - 1) * (2 * n)));
      if ((n & 1) != 0) begin
        sum = sum - $signed(t);
      end else begin
        sum = sum + $signed(t);
      end
    end
    return sum;
  endfunction

  // Ratio cos(a) / cos(60deg - a) per hue, signed, RATIO_FRAC_BITS fraction bits.
  function automatic ratio_rom_t build_ratio_rom();
    ratio_rom_t         rom;
    logic [31:0]        k;
    logic [31:0]        u;
    logic [31:0]        d;
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic [63:0]        mag;
    logic [63:0]        q;
    for (int h = 0; h < HUE_STEPS; h++) begin
      k = (h <= SECTOR_RG_MAX) ? 32'd0 : ((h <= SECTOR_GB_MAX) ? 32'd1 : 32'd2);
      u = 32'(3 * h) - 32'd256 * k;
      d = (u <= 32'd128) ? (32'd128 - u) : (u - 32'd128);
      num = cos_q28(u);
      den = cos_q28(d);
      if (den <= 0) begin
        den = 64'sd1;
      end
      mag = (num < 0) ? 64'(-num) : 64'(num);
      q   = udiv64((mag << RATIO_FRAC_BITS) + (64'(den) >> 1), 64'(den));
      rom[h] = (num < 0) ? RATIO_W'(-q) : RATIO_W'(q);
    end
    return rom;
  endfunction

  localparam ratio_rom_t RATIO_ROM = build_ratio_rom();

endpackage

### src/hsi2rgb_front.sv
// Front end: takes a pixel transaction, picks its hue sector and ratio.
// Depends on hsi2rgb_pkg.
module hsi2rgb_front import hsi2rgb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  hsi_t   hsi,
  output qxfer_t push,
  input  logic   full
);

  logic    held;
  qentry_t entry;
  logic    take;

  // The holding register frees up when it is empty or drains this cycle.
  assign take = !held || !full;
  assign busy = !take;

  assign push.valid = held && !full;
  assign push.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (start && take) begin
      held <= 1'b1;
    end else if (push.valid) begin
      held <= 1'b0;
    end
    if (start && take) begin
      if (hsi.hue <= 8'(SECTOR_RG_MAX)) begin
        entry.sector <= SECTOR_RG;
      end else if (hsi.hue <= 8'(SECTOR_GB_MAX)) begin
        entry.sector <= SECTOR_GB;
      end else begin
        entry.sector <= SECTOR_BR;
      end
      entry.saturation <= hsi.saturation;
      entry.intensity  <= hsi.intensity;
      entry.ratio      <= RATIO_ROM[hsi.hue];
    end
  end

endmodule

### src/hsi2rgb_queue.sv
// Short FIFO between the front end and the arithmetic back end.
// Depends on hsi2rgb_pkg and the assertion macro header.
`include "hsi_to_rgb_pixel_assert.svh"
module hsi2rgb_queue import hsi2rgb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  qxfer_t push,
  output logic   full,
  output qxfer_t head,
  input  logic   pop
);

  qentry_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              empty;

  assign empty      = (count == '0);
  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = !empty;
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  `HSI2RGB_ASSERT_NEVER(a_no_overflow, push.valid && full && !pop, "queue overflow")
  `HSI2RGB_ASSERT_NEVER(a_no_underflow, pop && empty, "queue underflow")

endmodule

### src/hsi2rgb_back.sv
// Arithmetic back end: channel products, the third channel, rounding and routing.
// Depends on hsi2rgb_pkg.
module hsi2rgb_back import hsi2rgb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  qxfer_t head,
  output logic   pop,
  output logic   done,
  output rgb_t   rgb
);

  localparam int SR_W   = RATIO_W + 9;
  localparam int LF_W   = SR_W + 1;
  localparam int CHAN_W = LF_W + 9;
  localparam int SHIFT  = RATIO_FRAC_BITS + 8;
  localparam int Q_W    = CHAN_W - SHIFT;

  // Round to nearest, ties to even, then clamp to 0..255.
  function automatic logic [7:0] round_clamp(input logic signed [CHAN_W-1:0] v);
    logic [Q_W-1:0]   q;
    logic [SHIFT-1:0] rem;
    logic [SHIFT-1:0] half;
    logic             up;
    logic [Q_W:0]     qn;
    q    = v[CHAN_W-1:SHIFT];
    rem  = v[SHIFT-1:0];
    half = SHIFT'(1) << (SHIFT - 1);
    up   = (rem > half) || ((rem == half) && q[0]);
    qn   = {1'b0, q} + (Q_W + 1)'(up);
    if (v <= 0) begin
      return 8'd0;
    end else if (qn > (Q_W + 1)'(255)) begin
      return 8'd255;
    end else begin
      return qn[7:0];
    end
  endfunction

  logic [4:1]                v;
  sector_t                   sec1, sec2, sec3, sec4;
  logic [7:0]                int1, int2;
  logic [9:0]                int3;
  logic signed [SR_W-1:0]    sr1;
  logic signed [LF_W-1:0]    lf2;
  logic [16:0]               tr1, tr2, tr3;
  logic signed [CHAN_W-1:0]  lead3, lead4, trail4, third4;
  logic signed [CHAN_W-1:0]  trail3_v;
  logic [7:0]                t_ch, l_ch, r_ch;

  // The back end never stalls, so it drains the queue whenever it holds work.
  assign pop = head.valid;

  assign trail3_v = $signed({{(CHAN_W - 17 - RATIO_FRAC_BITS){1'b0}}, tr3,
                             {RATIO_FRAC_BITS{1'b0}}});

  assign t_ch = round_clamp(trail4);
  assign l_ch = round_clamp(lead4);
  assign r_ch = round_clamp(third4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[3:1], head.valid};
      done <= v[4];
    end
    // Stage 1: saturation times ratio, and the trailing product.
    sec1 <= head.entry.sector;
    int1 <= head.entry.intensity;
    sr1  <= $signed({1'b0, head.entry.saturation}) * head.entry.ratio;
    tr1  <= head.entry.intensity * (9'd256 - {1'b0, head.entry.saturation});
    // Stage 2: leading factor 256 + S * ratio.
    sec2 <= sec1;
    int2 <= int1;
    tr2  <= tr1;
    lf2  <= {sr1[SR_W-1], sr1} + (LF_W'(1) << SHIFT);
    // Stage 3: leading channel at full scale.
    sec3  <= sec2;
    tr3   <= tr2;
    int3  <= {2'b00, int2} + {1'b0, int2, 1'b0};
    lead3 <= $signed({1'b0, int2}) * lf2;
    // Stage 4: third channel as 3I minus the other two.
    sec4   <= sec3;
    lead4  <= lead3;
    trail4 <= trail3_v;
    third4 <= $signed(CHAN_W'(int3) << SHIFT) - lead3 - trail3_v;
    // Output: round, clamp and place each channel by sector.
    case (sec4)
      SECTOR_RG: rgb <= '{blue: t_ch, green: r_ch, red: l_ch};
      SECTOR_GB: rgb <= '{blue: r_ch, green: l_ch, red: t_ch};
      SECTOR_BR: rgb <= '{blue: l_ch, green: t_ch, red: r_ch};
      default:   rgb <= '{blue: l_ch, green: t_ch, red: r_ch};
    endcase
  end

endmodule

### src/hsi_to_rgb_pixel.sv
// Top level of the HSI to RGB pixel converter.
// Depends on hsi2rgb_pkg, hsi2rgb_front, hsi2rgb_queue, hsi2rgb_back and the macro header.
//
// Usage:
//   A pixel transaction (hue, saturation, intensity) is accepted at a rising
//   clock edge where start is high and busy is low. Each pixel yields exactly
//   one result (blue, green, red) on rgb, marked by done for one cycle.
//   The receiver cannot hold results off; every done cycle is a delivery.
//   The result passes through one front register, one queue slot, four
//   arithmetic stages and the output register before done is seen high.
//   Throughput: one pixel per clock. The back end drains the queue every
//   cycle, so busy stays low in normal operation; it would only rise if the
//   queue were full and the front register still held a pixel.
//   Results leave in the order pixels were accepted.
//   Reset (rst, synchronous, active high) empties the front register, the
//   queue and the stage valid chain; pixels in flight are dropped and no
//   done strobe appears until a new pixel works its way through.
//   The hue ratio table is a constant built at elaboration; there is no
//   clearing pass and no configuration.
`include "hsi_to_rgb_pixel_assert.svh"
module hsi_to_rgb_pixel import hsi2rgb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  hsi_t hsi,
  output logic done,
  output rgb_t rgb
);

  qxfer_t push;
  qxfer_t head;
  logic   full;
  logic   pop;

  // Front end: classifies the pixel by hue sector and looks up its ratio.
  hsi2rgb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .hsi   (hsi),
    .push  (push),
    .full  (full)
  );

  // Decoupling queue between the front end and the back end, which never stalls.
  hsi2rgb_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  // Back end: fixed-point channel arithmetic, rounding, clamping and routing.
  hsi2rgb_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .done (done),
    .rgb  (rgb)
  );

  // Every result must come from an earlier accepted transaction.
  `HSI2RGB_ASSERT_IMP(a_done_latency, done,
                      $past(start && !busy && !rst, PIPE_LATENCY),
                      "done without matching transaction")
  // The back end never stalls, so the front end must never push back.
  `HSI2RGB_ASSERT_NEVER(a_never_busy, busy, "unexpected backpressure")

endmodule
